@@ hw/rtl/kmdl_pkg.sv @@
// ----------------------------------------------------------------------------
// kmdl_pkg: shared types and constants for the key matrix debounce latch
// Holds the per-slot state record, the configuration bundle handed to the
// slot update logic, and the register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kmdl_pkg;

  // Slot geometry
  localparam int unsigned KEY_SLOTS = 128;
  localparam int unsigned SLOT_W    = $clog2(KEY_SLOTS);
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Saturation point of the elapsed counters
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Latch register codes that mean "no latching key"
  localparam logic [SLOT_W-1:0] LATCH_NONE_LO = SLOT_W'(126);

  // Register index codes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_KEY_A    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_KEY_B    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_KEY_C    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_LOW    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_HIGH   = 3'd7;

  // Per-slot state record
  typedef struct packed {
    logic             physical;
    logic             logical;
    logic             pending;
    logic [CNT_W-1:0] debounce_elapsed;
    logic [CNT_W-1:0] press_elapsed;
    logic [CNT_W-1:0] release_elapsed;
  } slot_t;

  // Timing and latching configuration seen by the update logic
  typedef struct packed {
    logic [CNT_W-1:0]  debounce_count;
    logic [CNT_W-1:0]  press_delay;
    logic [CNT_W-1:0]  release_delay;
    logic [SLOT_W-1:0] latch_key_a;
    logic [SLOT_W-1:0] latch_key_b;
    logic [SLOT_W-1:0] latch_key_c;
  } cfg_t;

  // Outcome of one slot update
  typedef struct packed {
    logic  write;
    slot_t next;
    logic  report;
    logic  pressed;
  } upd_t;

endpackage

`default_nettype wire

@@ hw/rtl/key_matrix_debounce_latch.sv @@
// ----------------------------------------------------------------------------
// key_matrix_debounce_latch: debounced key matrix with latching keys
// Per-slot debounce and hold timing over a 128-entry state memory.
// ----------------------------------------------------------------------------
// Usage:
//   The scanner sends one item per sample (slot_index_i, switch_level_i) on
//   in_valid_i / in_stall_o. An item is taken at a clock edge with valid high
//   and stall low. A settled key change comes out as one item
//   (report_slot_o, report_pressed_o) on out_valid_o / out_stall_i.
//   Throughput: one item per cycle while in_stall_o is low. The slot record
//   is read from the state memory at the accepting edge, updated in the
//   update stage and written back as that stage completes; a sample for the
//   same slot taken at the write-back edge is forwarded. Reports are registered.
//   Stalls: a finished report waits in the output register while a new item
//   still enters; the input stalls only when a second report is ready and
//   the output register is still held by out_stall_i.
//   Reset: all slot records read as zero through per-slot valid flops, so no
//   clearing pass is needed; registers return to their reset values.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i
//   while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_latch (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [kmdl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kmdl_pkg::CFG_W-1:0]       cfg_data_i,
  // Sample channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [kmdl_pkg::SLOT_W-1:0]      slot_index_i,
  input  logic                             switch_level_i,
  // Report channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [kmdl_pkg::SLOT_W-1:0]      report_slot_o,
  output logic                             report_pressed_o
);
  import kmdl_pkg::*;

  // Configuration registers
  cfg_t             cfg_q;
  logic [CFG_W-1:0] present_low_q;
  logic [CFG_W-1:0] present_high_q;

  // State memory and per-slot valid flags
  slot_t                mem_q [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] slot_valid_q;

  // Update stage
  logic              s1_valid_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              s1_level_q;
  slot_t             rd_q;
  logic              rd_vld_q;
  logic              fwd_q;
  slot_t             fwd_data_q;

  // Output register
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_pressed_q;

  logic                   in_accept;
  logic                   s1_done;
  logic [2*CFG_W-1:0]     present_w;
  logic                   s1_fitted;
  slot_t                  s1_cur;
  upd_t                   upd;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_count <= CNT_W'(1);
      cfg_q.press_delay    <= '0;
      cfg_q.release_delay  <= '0;
      cfg_q.latch_key_a    <= '1;
      cfg_q.latch_key_b    <= '1;
      cfg_q.latch_key_c    <= '1;
      present_low_q        <= '1;
      present_high_q       <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE_COUNT: cfg_q.debounce_count <= cfg_data_i[CNT_W-1:0];
        REG_PRESS_DELAY:    cfg_q.press_delay    <= cfg_data_i[CNT_W-1:0];
        REG_RELEASE_DELAY:  cfg_q.release_delay  <= cfg_data_i[CNT_W-1:0];
        REG_LATCH_KEY_A:    cfg_q.latch_key_a    <= cfg_data_i[SLOT_W-1:0];
        REG_LATCH_KEY_B:    cfg_q.latch_key_b    <= cfg_data_i[SLOT_W-1:0];
        REG_LATCH_KEY_C:    cfg_q.latch_key_c    <= cfg_data_i[SLOT_W-1:0];
        REG_PRESENT_LOW:    present_low_q        <= cfg_data_i;
        REG_PRESENT_HIGH:   present_high_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the update stage completes unless its report is blocked
  assign s1_done    = s1_valid_q && (!upd.report || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Select the current slot record: forwarded, stored, or reset value
  always_comb begin
    if (fwd_q) begin
      s1_cur = fwd_data_q;
    end else if (rd_vld_q) begin
      s1_cur = rd_q;
    end else begin
      s1_cur = '0;
    end
  end

  assign present_w = {present_high_q, present_low_q};
  assign s1_fitted = present_w[s1_slot_q];

  kmdl_slot_update u_update (
    .cfg_i    (cfg_q),
    .slot_i   (s1_slot_q),
    .level_i  (s1_level_q),
    .fitted_i (s1_fitted),
    .cur_i    (s1_cur),
    .upd_o    (upd)
  );

  // Advance the update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_done && upd.write && (s1_slot_q == slot_index_i);
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item and read its slot record
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_slot_q  <= slot_index_i;
      s1_level_q <= switch_level_i;
      rd_q       <= mem_q[slot_index_i];
      rd_vld_q   <= slot_valid_q[slot_index_i];
      fwd_data_q <= upd.next;
    end
  end

  // Write back the updated slot record
  always_ff @(posedge clk_i) begin
    if (s1_done && upd.write) begin
      mem_q[s1_slot_q] <= upd.next;
    end
  end

  // Mark slots written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (s1_done && upd.write) begin
      slot_valid_q[s1_slot_q] <= 1'b1;
    end
  end

  // Hold or load the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_done && upd.report) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && upd.report) begin
      out_slot_q    <= s1_slot_q;
      out_pressed_q <= upd.pressed;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign report_slot_o    = out_slot_q;
  assign report_pressed_o = out_pressed_q;

endmodule

`default_nettype wire

@@ hw/rtl/kmdl_slot_update.sv @@
// ----------------------------------------------------------------------------
// kmdl_slot_update: next-state logic for one key slot
// Applies one switch sample to a slot record: debounce, press and release
// hold timing, momentary or latching logical state, and the settle report.
// ----------------------------------------------------------------------------
`default_nettype none

module kmdl_slot_update (
  input  kmdl_pkg::cfg_t                  cfg_i,
  input  logic [kmdl_pkg::SLOT_W-1:0]     slot_i,
  input  logic                            level_i,
  input  logic                            fitted_i,
  input  kmdl_pkg::slot_t                 cur_i,
  output kmdl_pkg::upd_t                  upd_o
);
  import kmdl_pkg::*;

  logic             latching;
  logic             use_press;
  logic [CNT_W-1:0] hold_elapsed;
  logic [CNT_W-1:0] hold_delay;
  logic             hold_over;
  logic [CNT_W-1:0] hold_next;

  // Match the slot against the three latch registers
  always_comb begin
    latching = ((cfg_i.latch_key_a < LATCH_NONE_LO) && (cfg_i.latch_key_a == slot_i)) ||
               ((cfg_i.latch_key_b < LATCH_NONE_LO) && (cfg_i.latch_key_b == slot_i)) ||
               ((cfg_i.latch_key_c < LATCH_NONE_LO) && (cfg_i.latch_key_c == slot_i));
  end

  // Pick the hold counter pair for this change
  always_comb begin
    if (latching) begin
      use_press = !cur_i.logical;
    end else begin
      use_press = level_i;
    end
    hold_elapsed = use_press ? cur_i.press_elapsed : cur_i.release_elapsed;
    hold_delay   = use_press ? cfg_i.press_delay   : cfg_i.release_delay;
    hold_over    = (hold_elapsed >= hold_delay);
    hold_next    = (hold_elapsed < CNT_MAX) ? hold_elapsed + CNT_W'(1) : hold_elapsed;
  end

  // Build the new slot record and the report
  always_comb begin
    upd_o.write   = fitted_i;
    upd_o.next    = cur_i;
    upd_o.report  = 1'b0;
    upd_o.pressed = cur_i.logical;
    if (cur_i.physical == level_i) begin
      // Agreeing level: settle and report once
      if (cur_i.pending) begin
        upd_o.next.pending          = 1'b0;
        upd_o.next.debounce_elapsed = '0;
        upd_o.next.press_elapsed    = '0;
        upd_o.next.release_elapsed  = '0;
        upd_o.report                = fitted_i;
      end
    end else begin
      upd_o.next.pending = 1'b1;
      if (cur_i.debounce_elapsed < cfg_i.debounce_count) begin
        // Still debouncing
        upd_o.next.debounce_elapsed = cur_i.debounce_elapsed + CNT_W'(1);
      end else if (latching && !level_i) begin
        // Latching key takes a release at once
        upd_o.next.physical = level_i;
      end else if (hold_over) begin
        // Hold is over: take the level
        upd_o.next.physical = level_i;
        if (latching) begin
          upd_o.next.logical = !cur_i.logical;
        end else begin
          upd_o.next.logical = level_i;
        end
      end else begin
        // Advance the hold counter
        if (use_press) begin
          upd_o.next.press_elapsed = hold_next;
        end else begin
          upd_o.next.release_elapsed = hold_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kmdl_port_chk.sv @@
// ----------------------------------------------------------------------------
// kmdl_port_chk: port-level checks for the key matrix debounce latch
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module kmdl_port_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [kmdl_pkg::SLOT_W-1:0]      report_slot_o,
  input logic                             report_pressed_o
);

  // A stalled report holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(report_slot_o) && $stable(report_pressed_o)))
    else $error("stalled report changed");

  // The input stalls only behind a blocked report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with free output register");

  // A fresh report follows a taken item that passed through the update stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("report without a matching item");

endmodule

bind key_matrix_debounce_latch kmdl_port_chk u_kmdl_port_chk (.*);

`default_nettype wire
